// ===== design/cws_pkg.sv =====
package cws_pkg;

    // Default sizes of the head array
    localparam int HEADS_DEF       = 12;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field widths at the ports
    localparam int HEAD_W     = 4;
    localparam int IN_WEIGHT_W = 16;
    localparam int STATUS_W   = 2;
    localparam int ROW_W      = 12;
    localparam int TOTAL_W    = 20;
    localparam int COUNT_W    = 4;
    localparam int TARGET_W   = 20;
    localparam int CFG_IDX_W  = 1;

    // Item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Head status codes
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMB  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TTT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TGU   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    // Per-status head counts
    typedef struct packed {
        logic [COUNT_W-1:0] free_cnt;
        logic [COUNT_W-1:0] ttt_cnt;
        logic [COUNT_W-1:0] tgu_cnt;
    } t_counts;

endpackage

// ===== design/cws_row_sum.sv =====
module cws_row_sum
    import cws_pkg::*;
#(
    parameter int HEADS       = HEADS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    localparam int SUM_W      = WEIGHT_BITS + $clog2(HEADS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [HEADS-1:0]       i_row,
    input  logic [HEADS-1:0]       i_members,
    input  logic [WEIGHT_BITS-1:0] i_weights [HEADS],
    output logic                   o_valid,
    output logic                   o_busy,
    output logic [HEADS-1:0]       o_row,
    output logic [HEADS-1:0]       o_members,
    output logic [SUM_W-1:0]       o_sum
);

    localparam int GROUPS = (HEADS + 3) / 4;
    localparam int GW     = WEIGHT_BITS + 2;

    logic [GW-1:0]          n_psum [GROUPS];
    logic [GW-1:0]          r_psum [GROUPS];
    logic [HEADS-1:0]       r_row1, r_mem1, r_row2, r_mem2;
    logic                   r_v1, r_v2;
    logic [SUM_W-1:0]       n_sum, r_sum;

    // Masked partial sums over groups of four heads
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_psum[g] = '0;
            for (int k = 0; k < 4; k++) begin
                if (g * 4 + k < HEADS) begin
                    if (i_members[g * 4 + k]) begin
                        n_psum[g] = n_psum[g] + GW'(i_weights[g * 4 + k]);
                    end
                end
            end
        end
    end

    // Combine the registered partials
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_sum = n_sum + SUM_W'(r_psum[g]);
        end
    end

    // Hold payload of both stages
    always_ff @(posedge i_clk) begin
        r_psum <= n_psum;
        r_row1 <= i_row;
        r_mem1 <= i_members;
        r_sum  <= n_sum;
        r_row2 <= r_row1;
        r_mem2 <= r_mem1;
    end

    // Advance the stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid   = r_v2;
    assign o_busy    = r_v1 | r_v2;
    assign o_row     = r_row2;
    assign o_members = r_mem2;
    assign o_sum     = r_sum;

endmodule

// ===== design/cws_head_count.sv =====
module cws_head_count
    import cws_pkg::*;
#(
    parameter int HEADS = HEADS_DEF
) (
    input  logic [STATUS_W-1:0] i_states [HEADS],
    output t_counts             o_counts
);

    localparam int CW = $clog2(HEADS + 1);

    logic [HEADS-1:0] comb_v, ttt_v, tgu_v;
    logic [CW-1:0]    n_free, n_ttt, n_tgu;

    // Flag heads per status
    always_comb begin
        for (int j = 0; j < HEADS; j++) begin
            comb_v[j] = (i_states[j] == ST_COMB);
            ttt_v[j]  = (i_states[j] == ST_TTT);
            tgu_v[j]  = (i_states[j] == ST_TGU);
        end
    end

    assign n_free = CW'($countones(comb_v));
    assign n_ttt  = CW'($countones(ttt_v));
    assign n_tgu  = CW'($countones(tgu_v));

    // Saturate counts to the field width
    function automatic logic [COUNT_W-1:0] sat(input logic [CW-1:0] n);
        logic [CW+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, n};
        if (w > (CW + COUNT_W)'({COUNT_W{1'b1}})) begin
            sat = {COUNT_W{1'b1}};
        end else begin
            sat = w[COUNT_W-1:0];
        end
    endfunction

    assign o_counts.free_cnt = sat(n_free);
    assign o_counts.ttt_cnt  = sat(n_ttt);
    assign o_counts.tgu_cnt  = sat(n_tgu);

endmodule

// ===== design/combination_weigher_subset_search_unit.sv =====
// Multihead combination weigher subset search.
// Input channel (i_valid / o_stall) carries one request: a write of one head's
// weight and status (i_kind = 0) or a combination search (i_kind = 1). A request
// is taken when i_valid is high and o_stall is low; o_stall stays high while a
// request is in work. Results leave on o_valid / i_stall, one per request, held
// in an output register until taken, so the next request can be taken while a
// result waits. Targets are written on the cfg channel (always ready), by the user
// only while idle; the block itself does not enforce this. A write request passes
// through the finish state into the output register. A search steps one subset row
// per cycle through a two-stage masked adder tree until a hit or until all 2^HEADS
// rows have been issued; the row walk is the limit. A new request is taken the cycle
// after the result register is loaded, so requests go one at a time. A stalled
// receiver holds the result and, once the request in work has finished, holds off
// the next load; inputs are then stalled.
// Reset clears all head states to empty, the search pointer and the targets to
// zero and empties the output register.
module combination_weigher_subset_search_unit
    import cws_pkg::*;
#(
    parameter int HEADS       = HEADS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_kind,
    input  logic [HEAD_W-1:0]      i_head,
    input  logic [IN_WEIGHT_W-1:0] i_weight,
    input  logic [STATUS_W-1:0]    i_status,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_found,
    output logic [ROW_W-1:0]       o_row,
    output logic [ROW_W-1:0]       o_heads_used,
    output logic [TOTAL_W-1:0]     o_total,
    output logic [COUNT_W-1:0]     o_free_count,
    output logic [COUNT_W-1:0]     o_ttt_count,
    output logic [COUNT_W-1:0]     o_tgu_count,
    // configuration channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [TARGET_W-1:0]    i_cfg_data
);

    localparam int SUM_W = WEIGHT_BITS + $clog2(HEADS);
    localparam int CMP_W = SUM_W + TARGET_W;
    localparam logic [HEADS:0] ROWS = {1'b1, {HEADS{1'b0}}};

    t_state                 r_state, n_state;
    logic [WEIGHT_BITS-1:0] r_weight [HEADS];
    logic [STATUS_W-1:0]    r_hstate [HEADS];
    logic [HEADS-1:0]       r_start, n_start;
    logic [HEADS-1:0]       r_row, n_row;
    logic [HEADS:0]         r_issued, n_issued;
    logic [TARGET_W-1:0]    r_tlow, r_thigh;

    logic                   r_res_found, n_res_found;
    logic [ROW_W-1:0]       r_res_row, n_res_row;
    logic [ROW_W-1:0]       r_res_used, n_res_used;
    logic [TOTAL_W-1:0]     r_res_total, n_res_total;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_found;
    logic [ROW_W-1:0]       r_out_row, r_out_used;
    logic [TOTAL_W-1:0]     r_out_total;
    t_counts                r_out_counts;
    logic                   out_load;

    logic                   accept, head_wr, issue, hit, none;
    logic [HEADS-1:0]       comb_mask, members;
    logic [WEIGHT_BITS+IN_WEIGHT_W-1:0] wr_ext;
    logic                   s_valid, s_busy;
    logic [HEADS-1:0]       s_row, s_members;
    logic [SUM_W-1:0]       s_sum;
    logic [CMP_W-1:0]       sum_x, low_x, high_x;
    t_counts                counts;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign head_wr = accept && (i_kind == KIND_WRITE);
    assign wr_ext  = {{WEIGHT_BITS{1'b0}}, i_weight};

    // Heads that may join a combination
    always_comb begin
        for (int j = 0; j < HEADS; j++) begin
            comb_mask[j] = (r_hstate[j] == ST_COMB);
        end
    end
    assign members = ~r_row & comb_mask;

    // Widen an internal row vector to the port width
    function automatic logic [ROW_W-1:0] row_out(input logic [HEADS-1:0] v);
        logic [HEADS+ROW_W-1:0] w;
        w = {{ROW_W{1'b0}}, v};
        row_out = w[ROW_W-1:0];
    endfunction

    // Head register file
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < HEADS; j++) begin
            if (head_wr && i_head == HEAD_W'(j)) begin
                r_weight[j] <= wr_ext[WEIGHT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < HEADS; j++) begin
                r_hstate[j] <= ST_EMPTY;
            end
        end else begin
            for (int j = 0; j < HEADS; j++) begin
                if (head_wr && i_head == HEAD_W'(j)) begin
                    r_hstate[j] <= i_status;
                end
            end
        end
    end

    // Target registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlow  <= '0;
            r_thigh <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TARGET_LOW:  r_tlow  <= i_cfg_data;
                CFG_TARGET_HIGH: r_thigh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Masked adder tree for the row walk
    cws_row_sum #(
        .HEADS       (HEADS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (issue),
        .i_row     (r_row),
        .i_members (members),
        .i_weights (r_weight),
        .o_valid   (s_valid),
        .o_busy    (s_busy),
        .o_row     (s_row),
        .o_members (s_members),
        .o_sum     (s_sum)
    );

    cws_head_count #(
        .HEADS (HEADS)
    ) u_count (
        .i_states (r_hstate),
        .o_counts (counts)
    );

    // Window test on the registered sum
    assign sum_x  = {{TARGET_W{1'b0}}, s_sum};
    assign low_x  = {{SUM_W{1'b0}}, r_tlow};
    assign high_x = {{SUM_W{1'b0}}, r_thigh};
    assign hit    = (r_state == S_SEARCH) && s_valid && (sum_x >= low_x) && (sum_x <= high_x);
    assign none   = (r_state == S_SEARCH) && (r_issued == ROWS) && !s_busy;
    assign issue  = (r_state == S_SEARCH) && !hit && (r_issued != ROWS);
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || !i_stall);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_row       = r_row;
        n_issued    = r_issued;
        n_res_found = r_res_found;
        n_res_row   = r_res_row;
        n_res_used  = r_res_used;
        n_res_total = r_res_total;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_found = 1'b0;
                    n_res_row   = '0;
                    n_res_used  = '0;
                    n_res_total = '0;
                    if (i_kind == KIND_SEARCH) begin
                        n_row    = r_start;
                        n_issued = '0;
                        n_state  = S_SEARCH;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_res_found = 1'b1;
                    n_res_row   = row_out(s_row);
                    n_res_used  = row_out(s_members);
                    n_res_total = TOTAL_W'({{TOTAL_W{1'b0}}, s_sum});
                    n_start     = s_row + 1'b1;
                    n_state     = S_FINISH;
                end else if (none) begin
                    n_start = r_start + 1'b1;
                    n_state = S_FINISH;
                end else if (issue) begin
                    n_row    = r_row + 1'b1;
                    n_issued = r_issued + 1'b1;
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= '0;
            r_row    <= '0;
            r_issued <= '0;
        end else begin
            r_state  <= n_state;
            r_start  <= n_start;
            r_row    <= n_row;
            r_issued <= n_issued;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_found <= n_res_found;
        r_res_row   <= n_res_row;
        r_res_used  <= n_res_used;
        r_res_total <= n_res_total;
    end

    // Output register: load on finish, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found  <= r_res_found;
            r_out_row    <= r_res_row;
            r_out_used   <= r_res_used;
            r_out_total  <= r_res_total;
            r_out_counts <= counts;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_row        = r_out_row;
    assign o_heads_used = r_out_used;
    assign o_total      = r_out_total;
    assign o_free_count = r_out_counts.free_cnt;
    assign o_ttt_count  = r_out_counts.ttt_cnt;
    assign o_tgu_count  = r_out_counts.tgu_cnt;

    // A miss carries no row, members or weight
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |->
        (r_out_row == '0 && r_out_used == '0 && r_out_total == '0))
        else $error("miss result carries nonzero fields");

    // A taken search request starts the row walk
    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_SEARCH) |=> (r_state == S_SEARCH && r_issued == '0))
        else $error("search request did not start the walk");

    // The walk never issues more than all rows
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_issued <= ROWS) && !(issue && r_issued == ROWS))
        else $error("row walk overran");

endmodule
